/* hdl/edpm_pkg.sv */
// Shared constants and beat types for the exact drift particle map.
package edpm_pkg;

    localparam int FRAC_BITS   = 24;
    localparam int SQRT_STEPS  = 32;
    localparam int DIV_STEPS   = 64;
    localparam int LANES       = 3;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] mom_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] mom_y;
        logic signed [31:0] path_delay;
        logic signed [31:0] energy_dev;
        logic signed [31:0] velocity_ratio;
    } t_in;

    typedef struct packed {
        logic signed [31:0] new_pos_x;
        logic signed [31:0] out_mom_x;
        logic signed [31:0] new_pos_y;
        logic signed [31:0] out_mom_y;
        logic signed [31:0] new_path_delay;
        logic signed [31:0] out_energy_dev;
        logic signed [31:0] out_velocity_ratio;
        logic [30:0]        long_momentum;
        logic               status;
    } t_out;

    typedef struct packed {
        t_in  item;
        logic arg_neg;
        logic qneg;
    } t_ctx;

endpackage

/* hdl/exact_drift_particle_map_unit.sv */
// Exact drift map: a fully pipelined square root, three dividers and the coordinate update.
//
//  channel  | handshake                        | payload
//  ---------+----------------------------------+-----------------------------
//  input    | i_valid / o_ready                | i_data (edpm_pkg::t_in)
//  output   | o_valid / i_ready                | o_data (edpm_pkg::t_out)
//  config   | i_cfg_we                         | i_cfg_data (drift length)
//
// One beat enters per cycle while the output is not stalled. The pipeline has four
// setup stages, one root bit per stage over 32 stages, one quotient bit per stage
// over 64 divider stages, and six stages of update and saturation.
// Reset clears the valid bits and the drift length. A stall on the output
// freezes the whole pipeline, so nothing is lost or repeated.
module exact_drift_particle_map_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  edpm_pkg::t_in     i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output edpm_pkg::t_out    o_data,
    input  logic              i_cfg_we,
    input  logic [30:0]       i_cfg_data
);

    localparam int F = edpm_pkg::FRAC_BITS;
    localparam int NS = edpm_pkg::SQRT_STEPS;
    localparam int ND = edpm_pkg::DIV_STEPS;
    localparam int NL = edpm_pkg::LANES;
    localparam logic signed [32:0] ONE33 = 33'sd1 <<< F;
    localparam logic signed [65:0] ONE66 = 66'sd1 <<< F;
    localparam logic [63:0] QCAP = 64'd1 << (33 + F);
    localparam logic [65:0] FCAP = 66'd1 << (32 + F);
    localparam logic [63:0] DCAP = 64'd1 << 33;

    function automatic logic [31:0] abs32(input logic signed [31:0] v);
        abs32 = v[31] ? (~v + 32'd1) : v;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647) begin
            sat32 = 32'sh7fffffff;
        end else if (v < -66'sd2147483648) begin
            sat32 = 32'sh80000000;
        end else begin
            sat32 = v[31:0];
        end
    endfunction

    logic w_ce;
    logic [30:0] r_len;

    // Setup stages
    logic                 r1_v, r2_v, r3_v;
    edpm_pkg::t_ctx       r1_ctx, r2_ctx, r3_ctx;
    logic [31:0]          r1_ua, r1_mpx, r1_mpy, r1_mv;
    logic [63:0]          r2_a, r2_px2, r2_py2, r3_a, r3_b;
    logic [NL-1:0][63:0]  r2_num, r3_num;

    // Square root stages
    logic                 r_sq_v    [0:NS];
    edpm_pkg::t_ctx       r_sq_ctx  [0:NS];
    logic [63:0]          r_sq_arg  [0:NS];
    logic [33:0]          r_sq_rem  [0:NS];
    logic [31:0]          r_sq_root [0:NS];
    logic [NL-1:0][63:0]  r_sq_num  [0:NS];
    logic [63:0]          n_sq_arg  [1:NS];
    logic [33:0]          n_sq_rem  [1:NS];
    logic [31:0]          n_sq_root [1:NS];

    // Divider stages; index 0 is the square root output
    logic                 r_dv_v    [1:ND];
    edpm_pkg::t_ctx       r_dv_ctx  [1:ND];
    logic [31:0]          r_dv_pz   [1:ND];
    logic [NL-1:0][31:0]  r_dv_rem  [1:ND];
    logic [NL-1:0][63:0]  r_dv_num  [1:ND];
    logic                 w_dv_v    [0:ND];
    edpm_pkg::t_ctx       w_dv_ctx  [0:ND];
    logic [31:0]          w_dv_pz   [0:ND];
    logic [NL-1:0][31:0]  w_dv_rem  [0:ND];
    logic [NL-1:0][63:0]  w_dv_num  [0:ND];
    logic [NL-1:0][31:0]  n_dv_rem  [1:ND];
    logic [NL-1:0][63:0]  n_dv_num  [1:ND];

    // Update stages
    logic                 r_p1_v, r_p2_v, r_p3_v, r_p4_v, r_p5_v, r_out_v;
    edpm_pkg::t_ctx       r_p1_ctx, r_p2_ctx, r_p3_ctx, r_p4_ctx, r_p5_ctx;
    logic [31:0]          r_p1_pz, r_p2_pz, r_p3_pz, r_p4_pz, r_p5_pz;
    logic signed [31:0]   r_p1_nx, r_p2_nx, r_p3_nx, r_p4_nx, r_p5_nx;
    logic signed [31:0]   r_p1_ny, r_p2_ny, r_p3_ny, r_p4_ny, r_p5_ny;
    logic [63:0]          r_p1_q;
    logic signed [65:0]   r_p2_f;
    logic                 r_p3_fneg, r_p4_fneg, r_p5_fneg;
    logic [65:0]          r_p3_fm;
    logic [63:0]          r_p4_hl, r_p4_ll;
    logic [33:0]          r_p5_dm;
    edpm_pkg::t_out       r_out;

    logic signed [32:0]   w_opd;
    logic [31:0]          w_ua;
    logic signed [65:0]   w_sx, w_sy, w_qx, w_qy, w_ds, w_fmag;
    logic [63:0]          w_dm;

    assign w_ce    = !r_out_v || i_ready;
    assign o_ready = w_ce;
    assign o_valid = r_out_v;
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
        end else if (i_cfg_we) begin
            r_len <= i_cfg_data;
        end
    end

    assign w_opd = {i_data.energy_dev[31], i_data.energy_dev} + ONE33;
    assign w_ua  = w_opd[32] ? 32'(-w_opd) : w_opd[31:0];

    // Setup: magnitudes, products, then the square root argument.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else if (w_ce) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r1_ctx.item    <= i_data;
            r1_ctx.arg_neg <= 1'b0;
            r1_ctx.qneg    <= i_data.velocity_ratio[31] != w_opd[32];
            r1_ua          <= w_ua;
            r1_mpx         <= abs32(i_data.mom_x);
            r1_mpy         <= abs32(i_data.mom_y);
            r1_mv          <= abs32(i_data.velocity_ratio);

            r2_ctx    <= r1_ctx;
            r2_a      <= 64'(r1_ua) * 64'(r1_ua);
            r2_px2    <= 64'(r1_mpx) * 64'(r1_mpx);
            r2_py2    <= 64'(r1_mpy) * 64'(r1_mpy);
            r2_num[0] <= 64'(r1_mpx) * 64'(r_len);
            r2_num[1] <= 64'(r1_mpy) * 64'(r_len);
            r2_num[2] <= 64'(r1_mv) * 64'(r1_ua);

            r3_ctx <= r2_ctx;
            r3_a   <= r2_a;
            r3_b   <= r2_px2 + r2_py2;
            r3_num <= r2_num;
        end
    end

    // One root bit per stage: bring down two argument bits and try 4r+1.
    always_comb begin
        logic [35:0] rem_s;
        logic [35:0] trial;
        for (int k = 0; k < NS; k++) begin
            rem_s = {r_sq_rem[k], r_sq_arg[k][63:62]};
            trial = {2'b00, r_sq_root[k], 2'b01};
            n_sq_arg[k+1] = {r_sq_arg[k][61:0], 2'b00};
            if (rem_s >= trial) begin
                n_sq_rem[k+1]  = 34'(rem_s - trial);
                n_sq_root[k+1] = {r_sq_root[k][30:0], 1'b1};
            end else begin
                n_sq_rem[k+1]  = rem_s[33:0];
                n_sq_root[k+1] = {r_sq_root[k][30:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= NS; k++) begin
                r_sq_v[k] <= 1'b0;
            end
        end else if (w_ce) begin
            r_sq_v[0] <= r3_v;
            for (int k = 1; k <= NS; k++) begin
                r_sq_v[k] <= r_sq_v[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            // Stage zero holds the argument and the flag for a non-positive one.
            r_sq_ctx[0]  <= '{item: r3_ctx.item, arg_neg: (r3_a <= r3_b),
                              qneg: r3_ctx.qneg};
            r_sq_arg[0]  <= r3_a - r3_b;
            r_sq_rem[0]  <= '0;
            r_sq_root[0] <= '0;
            r_sq_num[0]  <= r3_num;
            for (int k = 1; k <= NS; k++) begin
                r_sq_ctx[k]  <= r_sq_ctx[k-1];
                r_sq_arg[k]  <= n_sq_arg[k];
                r_sq_rem[k]  <= n_sq_rem[k];
                r_sq_root[k] <= n_sq_root[k];
                r_sq_num[k]  <= r_sq_num[k-1];
            end
        end
    end

    // Restoring division, one quotient bit per stage. The numerator register
    // shifts out dividend bits and shifts in quotient bits.
    always_comb begin
        w_dv_v[0]   = r_sq_v[NS];
        w_dv_ctx[0] = r_sq_ctx[NS];
        w_dv_pz[0]  = r_sq_root[NS];
        w_dv_rem[0] = '0;
        w_dv_num[0] = r_sq_num[NS];
        for (int k = 1; k <= ND; k++) begin
            w_dv_v[k]   = r_dv_v[k];
            w_dv_ctx[k] = r_dv_ctx[k];
            w_dv_pz[k]  = r_dv_pz[k];
            w_dv_rem[k] = r_dv_rem[k];
            w_dv_num[k] = r_dv_num[k];
        end
    end

    always_comb begin
        logic [32:0] rem_s;
        for (int k = 0; k < ND; k++) begin
            for (int l = 0; l < NL; l++) begin
                rem_s = {w_dv_rem[k][l], w_dv_num[k][l][63]};
                if (rem_s >= {1'b0, w_dv_pz[k]}) begin
                    n_dv_rem[k+1][l] = 32'(rem_s - {1'b0, w_dv_pz[k]});
                    n_dv_num[k+1][l] = {w_dv_num[k][l][62:0], 1'b1};
                end else begin
                    n_dv_rem[k+1][l] = rem_s[31:0];
                    n_dv_num[k+1][l] = {w_dv_num[k][l][62:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 1; k <= ND; k++) begin
                r_dv_v[k] <= 1'b0;
            end
        end else if (w_ce) begin
            for (int k = 1; k <= ND; k++) begin
                r_dv_v[k] <= w_dv_v[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            for (int k = 1; k <= ND; k++) begin
                r_dv_ctx[k] <= w_dv_ctx[k-1];
                r_dv_pz[k]  <= w_dv_pz[k-1];
                r_dv_rem[k] <= n_dv_rem[k];
                r_dv_num[k] <= n_dv_num[k];
            end
        end
    end

    // Update: positions, then the sigma factor and its product with L.
    assign w_qx = {2'b00, w_dv_num[ND][0]};
    assign w_qy = {2'b00, w_dv_num[ND][1]};
    assign w_sx = w_dv_ctx[ND].item.mom_x[31]
                ? 66'(w_dv_ctx[ND].item.pos_x) - w_qx
                : 66'(w_dv_ctx[ND].item.pos_x) + w_qx;
    assign w_sy = w_dv_ctx[ND].item.mom_y[31]
                ? 66'(w_dv_ctx[ND].item.pos_y) - w_qy
                : 66'(w_dv_ctx[ND].item.pos_y) + w_qy;
    assign w_fmag = r_p2_f[65] ? -r_p2_f : r_p2_f;
    assign w_dm = (r_p4_hl << (32 - F)) + (r_p4_ll >> F);
    assign w_ds = r_p5_fneg ? -$signed({32'd0, r_p5_dm}) : $signed({32'd0, r_p5_dm});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_v  <= 1'b0;
            r_p2_v  <= 1'b0;
            r_p3_v  <= 1'b0;
            r_p4_v  <= 1'b0;
            r_p5_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else if (w_ce) begin
            r_p1_v  <= w_dv_v[ND];
            r_p2_v  <= r_p1_v;
            r_p3_v  <= r_p2_v;
            r_p4_v  <= r_p3_v;
            r_p5_v  <= r_p4_v;
            r_out_v <= r_p5_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_p1_ctx <= w_dv_ctx[ND];
            r_p1_pz  <= w_dv_pz[ND];
            r_p1_nx  <= sat32(w_sx);
            r_p1_ny  <= sat32(w_sy);
            r_p1_q   <= (w_dv_num[ND][2] > QCAP) ? QCAP : w_dv_num[ND][2];

            r_p2_ctx <= r_p1_ctx;
            r_p2_pz  <= r_p1_pz;
            r_p2_nx  <= r_p1_nx;
            r_p2_ny  <= r_p1_ny;
            r_p2_f   <= r_p1_ctx.qneg ? ONE66 + $signed({2'b00, r_p1_q})
                                      : ONE66 - $signed({2'b00, r_p1_q});

            r_p3_ctx  <= r_p2_ctx;
            r_p3_pz   <= r_p2_pz;
            r_p3_nx   <= r_p2_nx;
            r_p3_ny   <= r_p2_ny;
            r_p3_fneg <= r_p2_f[65];
            r_p3_fm   <= ($unsigned(w_fmag) > FCAP) ? FCAP : $unsigned(w_fmag);

            r_p4_ctx  <= r_p3_ctx;
            r_p4_pz   <= r_p3_pz;
            r_p4_nx   <= r_p3_nx;
            r_p4_ny   <= r_p3_ny;
            r_p4_fneg <= r_p3_fneg;
            r_p4_hl   <= 64'(r_p3_fm[63:32]) * 64'(r_len);
            r_p4_ll   <= 64'(r_p3_fm[31:0]) * 64'(r_len);

            r_p5_ctx  <= r_p4_ctx;
            r_p5_pz   <= r_p4_pz;
            r_p5_nx   <= r_p4_nx;
            r_p5_ny   <= r_p4_ny;
            r_p5_fneg <= r_p4_fneg;
            r_p5_dm   <= (w_dm > DCAP) ? DCAP[33:0] : w_dm[33:0];

            r_out.out_mom_x          <= r_p5_ctx.item.mom_x;
            r_out.out_mom_y          <= r_p5_ctx.item.mom_y;
            r_out.out_energy_dev     <= r_p5_ctx.item.energy_dev;
            r_out.out_velocity_ratio <= r_p5_ctx.item.velocity_ratio;
            if (r_p5_ctx.arg_neg) begin
                r_out.new_pos_x      <= '0;
                r_out.new_pos_y      <= '0;
                r_out.new_path_delay <= '0;
                r_out.long_momentum  <= '0;
                r_out.status         <= 1'b1;
            end else begin
                r_out.new_pos_x      <= r_p5_nx;
                r_out.new_pos_y      <= r_p5_ny;
                r_out.new_path_delay <= sat32(66'(r_p5_ctx.item.path_delay) + w_ds);
                r_out.long_momentum  <= r_p5_pz[31] ? 31'h7fffffff : r_p5_pz[30:0];
                r_out.status         <= 1'b0;
            end
        end
    end

endmodule
